### rtl/utf8bp_pkg.sv
// Shared types, byte-class constants and decode functions for the UTF-8 prefix measurer.
package utf8bp_pkg;

  localparam int LEN_W   = 16;
  localparam int WIDTH_W = 3;
  localparam int BYTE_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [LEN_W-1:0] LIMIT_RESET = 16'd256;
  localparam logic CFG_IDX_LIMIT = 1'b0;

  localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_TAG   = 8'h80;
  localparam logic [BYTE_W-1:0] ASCII_MAX  = 8'h7F;
  localparam logic [BYTE_W-1:0] LEAD2_MIN  = 8'hC2;
  localparam logic [BYTE_W-1:0] LEAD2_MAX  = 8'hDF;
  localparam logic [BYTE_W-1:0] LEAD3_MIN  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD3_MAX  = 8'hEF;
  localparam logic [BYTE_W-1:0] LEAD_SURR  = 8'hED;
  localparam logic [BYTE_W-1:0] E0_LOW     = 8'hA0;
  localparam logic [BYTE_W-1:0] ED_HIGH    = 8'h9F;
  localparam logic [BYTE_W-1:0] LEAD4_MIN  = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD4_MAX  = 8'hF4;
  localparam logic [BYTE_W-1:0] F0_LOW     = 8'h90;
  localparam logic [BYTE_W-1:0] F4_HIGH    = 8'h8F;

  typedef struct packed {
    logic [LEN_W-1:0]   kept_length;
    logic [WIDTH_W-1:0] char_width;
    logic [WIDTH_W-1:0] bytes_seen;
    logic [BYTE_W-1:0]  lead_value;
    logic               stopped;
  } scan_state_t;

  localparam scan_state_t SCAN_CLEAR = '0;

  function automatic logic is_cont(input logic [BYTE_W-1:0] b);
    return (b & CONT_MASK) == CONT_TAG;
  endfunction

  function automatic logic [WIDTH_W-1:0] lead_width(input logic [BYTE_W-1:0] b);
    logic [WIDTH_W-1:0] w;
    w = 3'd0;
    if (b <= ASCII_MAX) w = 3'd1;
    else if (b >= LEAD2_MIN && b <= LEAD2_MAX) w = 3'd2;
    else if (b >= LEAD3_MIN && b <= LEAD3_MAX) w = 3'd3;
    else if (b >= LEAD4_MIN && b <= LEAD4_MAX) w = 3'd4;
    return w;
  endfunction

  function automatic logic second_ok(input logic [BYTE_W-1:0] lead,
                                     input logic [BYTE_W-1:0] b);
    logic ok;
    ok = 1'b1;
    if (lead == LEAD3_MIN && b < E0_LOW) ok = 1'b0;
    if (lead == LEAD_SURR && b > ED_HIGH) ok = 1'b0;
    if (lead == LEAD4_MIN && b < F0_LOW) ok = 1'b0;
    if (lead == LEAD4_MAX && b > F4_HIGH) ok = 1'b0;
    return ok;
  endfunction

endpackage

### rtl/utf8bp_cfg.sv
// APB-style register file holding the byte limit.
module utf8bp_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [utf8bp_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [utf8bp_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [utf8bp_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                              cfg_pready,
  output logic [utf8bp_pkg::LEN_W-1:0]      byte_limit
);
  import utf8bp_pkg::*;

  logic [LEN_W-1:0] byte_limit_r;
  logic [LEN_W-1:0] byte_limit_nxt;
  logic             reg_sel;

  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[CFG_ADDR_W-1] == CFG_IDX_LIMIT;

  always_comb begin
    byte_limit_nxt = byte_limit_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && reg_sel) begin
      byte_limit_nxt = cfg_pwdata[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_limit_r <= LIMIT_RESET;
    end else begin
      byte_limit_r <= byte_limit_nxt;
    end
  end

  assign cfg_prdata = reg_sel ? {{(CFG_DATA_W-LEN_W){1'b0}}, byte_limit_r} : '0;
  assign byte_limit = byte_limit_r;

endmodule

### rtl/utf8bp_core.sv
// Per-byte UTF-8 scan state and next-state logic.
module utf8bp_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          take,
  input  logic [utf8bp_pkg::BYTE_W-1:0] data_byte,
  input  logic                          last_byte,
  input  logic [utf8bp_pkg::LEN_W-1:0]  byte_limit,
  output logic [utf8bp_pkg::LEN_W-1:0]  prefix_length
);
  import utf8bp_pkg::*;

  scan_state_t        st_r;
  scan_state_t        st_nxt;
  scan_state_t        scan;
  logic [WIDTH_W-1:0] lw;
  logic [WIDTH_W-1:0] seen_inc;
  logic [WIDTH_W-1:0] done_w;
  logic               done;
  logic [LEN_W:0]     sum;

  assign lw       = lead_width(data_byte);
  assign seen_inc = st_r.bytes_seen + 3'd1;

  always_comb begin
    scan   = st_r;
    done   = 1'b0;
    done_w = lw;
    if (!st_r.stopped) begin
      if (st_r.char_width == 3'd0) begin
        if (lw == 3'd0) begin
          scan.stopped = 1'b1;
        end else if (lw == 3'd1) begin
          done = 1'b1;
        end else begin
          scan.char_width = lw;
          scan.bytes_seen = 3'd1;
          scan.lead_value = data_byte;
        end
      end else if (!is_cont(data_byte) ||
                   (st_r.bytes_seen == 3'd1 && !second_ok(st_r.lead_value, data_byte))) begin
        scan.stopped    = 1'b1;
        scan.char_width = 3'd0;
        scan.bytes_seen = 3'd0;
        scan.lead_value = '0;
      end else begin
        scan.bytes_seen = seen_inc;
        if (seen_inc >= st_r.char_width) begin
          done   = 1'b1;
          done_w = st_r.char_width;
        end
      end
    end
    sum = {1'b0, st_r.kept_length} + {{(LEN_W+1-WIDTH_W){1'b0}}, done_w};
    if (done) begin
      scan.char_width = 3'd0;
      scan.bytes_seen = 3'd0;
      scan.lead_value = '0;
      if (sum > {1'b0, byte_limit}) begin
        scan.stopped = 1'b1;
      end else begin
        scan.kept_length = sum[LEN_W-1:0];
      end
    end
  end

  always_comb begin
    st_nxt = st_r;
    if (take) begin
      st_nxt = last_byte ? SCAN_CLEAR : scan;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= SCAN_CLEAR;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign prefix_length = scan.kept_length;

endmodule

### rtl/utf8_bounded_prefix.sv
// Top level of the strict UTF-8 bounded-prefix measurer.
// Usage:
//   Input channel (in_valid/in_ready): one word per string byte, with
//   in_last_byte set on the final byte. Strings are never empty.
//   Result channel (out_valid/out_ready): one word per string, carrying the
//   byte length of the longest valid whole-character prefix that fits in
//   the byte limit.
//   Config port (cfg_*): byte limit at byte address 0, write only while idle.
// Timing:
//   One byte per clock sustained while in_ready is high. The scan state updates
//   in the cycle a word is accepted; the result is registered, so it appears in
//   the cycle after the final byte is accepted.
// Stall:
//   in_ready drops only while a result is held and out_ready is low; the
//   result register then holds until taken.
// Reset (rst_n, synchronous, active low):
//   clears the scan state and the output valid, and sets the byte limit to 256.
module utf8_bounded_prefix (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [utf8bp_pkg::BYTE_W-1:0]     in_data_byte,
  input  logic                              in_last_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [utf8bp_pkg::LEN_W-1:0]      out_prefix_length,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [utf8bp_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [utf8bp_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [utf8bp_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                              cfg_pready
);
  import utf8bp_pkg::*;

  logic [LEN_W-1:0] byte_limit;
  logic [LEN_W-1:0] scan_len;
  logic             take;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [LEN_W-1:0] out_len_r;
  logic [LEN_W-1:0] out_len_nxt;

  assign in_ready = !out_valid_r || out_ready;
  assign take     = in_valid && in_ready;

  utf8bp_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .byte_limit  (byte_limit)
  );

  utf8bp_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .take          (take),
    .data_byte     (in_data_byte),
    .last_byte     (in_last_byte),
    .byte_limit    (byte_limit),
    .prefix_length (scan_len)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_len_nxt   = out_len_r;
    if (take && in_last_byte) begin
      out_valid_nxt = 1'b1;
      out_len_nxt   = scan_len;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_len_r <= out_len_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_prefix_length = out_len_r;

endmodule
